[hdl/assert_macros.svh]
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the command parser RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge, skipping cycles where rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond implies prop in the same cycle, skipping reset cycles.
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Check that cond implies prop in the next cycle, skipping reset cycles.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[hdl/ducp_pkg.sv]
// -----------------------------------------------------------------------------
// ducp_pkg
// Types and constants shared by the delete-user command parser.
// -----------------------------------------------------------------------------
package ducp_pkg;

   typedef enum logic [2:0] {
      PH_DEL  = 3'd0,
      PH_USER = 3'd1,
      PH_NAME = 3'd2,
      PH_CR   = 3'd3,
      PH_DONE = 3'd4,
      PH_BAD  = 3'd5
   } phase_type;

   localparam logic [7:0] CHAR_PIPE = 8'h7C;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_E    = 8'h45;
   localparam logic [7:0] CHAR_L    = 8'h4C;
   localparam logic [7:0] CHAR_U    = 8'h55;
   localparam logic [7:0] CHAR_S    = 8'h53;
   localparam logic [7:0] CHAR_R    = 8'h52;

   localparam int DEL_LEN  = 3;
   localparam int USER_LEN = 4;

   // Result of one parser step, apart from the position.
   typedef struct packed {
      phase_type  phase;
      logic [1:0] write_count;
      logic [7:0] write_first;
      logic [7:0] write_second;
   } step_type;

   function automatic logic [7:0] del_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = CHAR_D;
         2'd1:    ch = CHAR_E;
         2'd2:    ch = CHAR_L;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] user_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = CHAR_U;
         2'd1:    ch = CHAR_S;
         2'd2:    ch = CHAR_E;
         default: ch = CHAR_R;
      endcase
      return ch;
   endfunction

endpackage

[hdl/delete_user_command_parser.sv]
// The result of a byte is registered and valid in the cycle after its transfer.
// Throughput: one byte per cycle, set by the single result register that req_ready
// tracks (a byte is taken whenever the result register is empty or being drained).
// Reset (synchronous, active high): phase returns to expecting DEL, position to zero,
// and no result is pending.
// -----------------------------------------------------------------------------
// delete_user_command_parser
// Parses DEL|USER|name CR LF one byte per transfer and reports status per byte.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module delete_user_command_parser #(
   parameter int MAX_NAME = 255
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_restart,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_name_length,
   output logic [1:0] rsp_write_count,
   output logic [7:0] rsp_write_first,
   output logic [7:0] rsp_write_second
);

   // Position holds a keyword letter index (up to 4) or the name length.
   localparam int PosBits  = $clog2(MAX_NAME + 1);
   localparam int PosWidth = (PosBits < 3) ? 3 : PosBits;

   // Parser state: only advanced by an accepted byte.
   ducp_pkg::phase_type  phase_ff;
   logic [PosWidth-1:0]  position_ff;

   // Result register.
   logic                 rsp_valid_ff;
   ducp_pkg::step_type   rsp_step_ff;
   logic [7:0]           rsp_length_ff;

   ducp_pkg::step_type   step_in;
   logic [PosWidth-1:0]  position_in;
   logic [PosWidth+7:0]  position_ext;
   logic [7:0]           length_in;
   logic                 req_xfer;

   // Take a new byte when the result register is empty or is drained this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   ducp_step #(
      .MAX_NAME  (MAX_NAME),
      .POS_WIDTH (PosWidth)
   ) u_step (
      .phase         (phase_ff),
      .position      (position_ff),
      .data_byte     (req_data_byte),
      .restart       (req_restart),
      .step          (step_in),
      .position_next (position_in)
   );

   // Report zero as the name length while a keyword is matched; other phases report the position.
   assign position_ext = {8'd0, position_in};
   assign length_in    = (step_in.phase inside {ducp_pkg::PH_DEL, ducp_pkg::PH_USER}) ?
                         8'd0 : position_ext[7:0];

   // Control state: phase, position and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ducp_pkg::PH_DEL;
         position_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            phase_ff    <= step_in.phase;
            position_ff <= position_in;
         end
         if (req_xfer) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: load on every accepted byte, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_step_ff   <= step_in;
         rsp_length_ff <= length_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_step_ff.phase;
   assign rsp_name_length  = rsp_length_ff;
   assign rsp_write_count  = rsp_step_ff.write_count;
   assign rsp_write_first  = rsp_step_ff.write_first;
   assign rsp_write_second = rsp_step_ff.write_second;

   // A restart transfer always yields a DEL status with nothing appended.
   `ASSERT_NEXT(a_restart_to_del, clock, reset, req_xfer && req_restart, rsp_valid && rsp_status == ducp_pkg::PH_DEL && rsp_write_count == 2'd0, "restart did not return parser to DEL")
   // Two appended bytes only come from a CR followed by an ordinary byte.
   `ASSERT_IMPLY(a_pair_in_name, clock, reset, rsp_valid && rsp_write_count == 2'd2, rsp_status == ducp_pkg::PH_NAME && rsp_write_first == ducp_pkg::CHAR_CR, "byte pair outside name phase")
   // Keyword phases never report name bytes.
   `ASSERT_IMPLY(a_keyword_no_name, clock, reset, rsp_valid && (rsp_status == ducp_pkg::PH_DEL || rsp_status == ducp_pkg::PH_USER), rsp_name_length == 8'd0 && rsp_write_count == 2'd0, "name data reported during keyword match")
   // The name never grows past its limit; a failed keyword keeps its letter index.
   `ASSERT_CLK(a_name_bound, clock, reset, position_ff <= PosWidth'(MAX_NAME) || position_ff <= PosWidth'(ducp_pkg::USER_LEN) || phase_ff == ducp_pkg::PH_DEL || phase_ff == ducp_pkg::PH_USER, "name length exceeds limit")

endmodule

[hdl/ducp_step.sv]
// -----------------------------------------------------------------------------
// ducp_step
// Next-state logic of the parser for one received byte.
// -----------------------------------------------------------------------------
module ducp_step #(
   parameter int MAX_NAME  = 255,
   parameter int POS_WIDTH = 8
) (
   input  ducp_pkg::phase_type    phase,
   input  logic [POS_WIDTH-1:0]   position,
   input  logic [7:0]             data_byte,
   input  logic                   restart,
   output ducp_pkg::step_type     step,
   output logic [POS_WIDTH-1:0]   position_next
);

   logic has_one;
   logic has_two;

   assign has_one = position < POS_WIDTH'(MAX_NAME);
   assign has_two = ({1'b0, position} + (POS_WIDTH + 1)'(2)) <= (POS_WIDTH + 1)'(MAX_NAME);

   always_comb begin
      step.phase        = phase;
      step.write_count  = 2'd0;
      step.write_first  = 8'd0;
      step.write_second = 8'd0;
      position_next     = position;
      if (restart) begin
         step.phase    = ducp_pkg::PH_DEL;
         position_next = '0;
      end else begin
         case (phase)
            ducp_pkg::PH_DEL: begin
               if (position >= POS_WIDTH'(ducp_pkg::DEL_LEN)) begin
                  if (data_byte == ducp_pkg::CHAR_PIPE) begin
                     step.phase    = ducp_pkg::PH_USER;
                     position_next = '0;
                  end else begin
                     step.phase = ducp_pkg::PH_BAD;
                  end
               end else if (data_byte == ducp_pkg::del_char(position[1:0])) begin
                  position_next = position + POS_WIDTH'(1);
               end else begin
                  step.phase = ducp_pkg::PH_BAD;
               end
            end
            ducp_pkg::PH_USER: begin
               if (position >= POS_WIDTH'(ducp_pkg::USER_LEN)) begin
                  if (data_byte == ducp_pkg::CHAR_PIPE) begin
                     step.phase    = ducp_pkg::PH_NAME;
                     position_next = '0;
                  end else begin
                     step.phase = ducp_pkg::PH_BAD;
                  end
               end else if (data_byte == ducp_pkg::user_char(position[1:0])) begin
                  position_next = position + POS_WIDTH'(1);
               end else begin
                  step.phase = ducp_pkg::PH_BAD;
               end
            end
            ducp_pkg::PH_NAME: begin
               if (data_byte == ducp_pkg::CHAR_PIPE) begin
                  step.phase = ducp_pkg::PH_BAD;
               end else if (data_byte == ducp_pkg::CHAR_CR) begin
                  step.phase = ducp_pkg::PH_CR;
               end else if (has_one) begin
                  position_next    = position + POS_WIDTH'(1);
                  step.write_count = 2'd1;
                  step.write_first = data_byte;
               end else begin
                  step.phase = ducp_pkg::PH_BAD;
               end
            end
            ducp_pkg::PH_CR: begin
               if (data_byte == ducp_pkg::CHAR_LF) begin
                  step.phase = (position == '0) ? ducp_pkg::PH_BAD : ducp_pkg::PH_DONE;
               end else if (data_byte == ducp_pkg::CHAR_PIPE) begin
                  step.phase = ducp_pkg::PH_BAD;
               end else if (data_byte == ducp_pkg::CHAR_CR) begin
                  // Keep the first CR as a name byte; stay after CR.
                  if (has_one) begin
                     position_next    = position + POS_WIDTH'(1);
                     step.write_count = 2'd1;
                     step.write_first = ducp_pkg::CHAR_CR;
                  end else begin
                     step.phase = ducp_pkg::PH_BAD;
                  end
               end else if (has_two) begin
                  position_next     = position + POS_WIDTH'(2);
                  step.write_count  = 2'd2;
                  step.write_first  = ducp_pkg::CHAR_CR;
                  step.write_second = data_byte;
                  step.phase        = ducp_pkg::PH_NAME;
               end else begin
                  step.phase = ducp_pkg::PH_BAD;
               end
            end
            default: begin
               // Finished and invalid hold until restart.
            end
         endcase
      end
   end

endmodule
